// ----- rtl/core/midiq_pkg.sv -----
// Package for the MIDI scale quantizer: widths, register indexes and the scale mask table.
// No dependencies; imported by midi_scale_quantizer.
package midiq_pkg;

    localparam int NoteW    = 7;
    localparam int PcW      = 4;
    localparam int PcCount  = 12;
    localparam int NoteMax  = 127;
    localparam int InDataW  = 8;
    localparam int OutDataW = 24;
    localparam int AddrW    = 3;
    localparam int DataW    = 32;

    typedef logic [PcCount-1:0] pc_mask_t;

    typedef enum logic
    {
        REG_ROOT_PITCH = 1'b0,
        REG_SCALE_MODE = 1'b1
    } reg_idx_t;

    function automatic pc_mask_t scale_mask(input logic [3:0] mode);
        pc_mask_t m;
        case (mode)
            4'd0:    m = 12'hAB5;
            4'd1:    m = 12'h5AD;
            4'd2:    m = 12'h9AD;
            4'd3:    m = 12'hAAD;
            4'd4:    m = 12'h6AD;
            4'd5:    m = 12'h5AB;
            4'd6:    m = 12'hAD5;
            4'd7:    m = 12'h6B5;
            4'd8:    m = 12'h295;
            4'd9:    m = 12'h4A9;
            4'd10:   m = 12'h4E9;
            4'd11:   m = 12'h1A3;
            4'd12:   m = 12'h5BB;
            4'd13:   m = 12'h555;
            4'd14:   m = 12'hB6D;
            default: m = 12'hFFF;
        endcase
        return m;
    endfunction

endpackage

// ----- rtl/core/midi_scale_quantizer.sv -----
// Top level of the MIDI scale quantizer: input register, note search, result register, APB regs.
// Depends on midiq_pkg.
//
// Takes one MIDI note per word on the s_ stream and returns, from its result register, the nearest
// scale tone (lower on a tie), the nearest tones at or above and at or below, and a membership
// flag. One note is accepted every cycle unless the output stalls; the two pipeline registers advance together
// whenever the result register is empty or being taken, so throughput is one word per cycle. The scale is a 12-bit
// pitch-class mask chosen by scale_mode and rotated up by root_pitch (values 12..15 wrap to 0..3). Write the
// registers only while the stream is idle.
module midi_scale_quantizer
    import midiq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [DataW-1:0]    pwdata,
    output logic [DataW-1:0]    prdata,
    output logic                pready,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // [6:0] note, [7] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata    // [6:0] nearest_note, [13:7] upper_note,
                                           // [20:14] lower_note, [21] member, [23:22] zero
);

    logic [3:0]       root_pitch_reg;
    logic [3:0]       scale_mode_reg;
    logic             in_valid_reg;
    logic [NoteW-1:0] in_note_reg;
    logic             out_valid_reg;
    logic [NoteW-1:0] nearest_reg;
    logic [NoteW-1:0] upper_reg;
    logic [NoteW-1:0] lower_reg;
    logic             member_reg;

    logic             advance;
    logic             cfg_write;
    reg_idx_t         cfg_idx;
    logic [3:0]       root_mod;
    pc_mask_t         base_mask;
    pc_mask_t         act_mask;
    pc_mask_t         rel_mask;
    logic [NoteW-1:0] n;
    logic [13:0]      quot_prod;
    logic [3:0]       quot;
    logic [PcW-1:0]   pc;
    logic             member;
    logic             have_up;
    logic             have_down;
    logic [3:0]       up_d;
    logic [3:0]       dn_d;
    logic [NoteW-1:0] up_note;
    logic [NoteW-1:0] dn_note;
    logic [NoteW-1:0] near_note;
    logic [NoteW-1:0] upper_next;
    logic [NoteW-1:0] lower_next;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_pitch_reg <= 4'd0;
            scale_mode_reg <= 4'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ROOT_PITCH: root_pitch_reg <= pwdata[3:0];
                REG_SCALE_MODE: scale_mode_reg <= pwdata[3:0];
                default:        root_pitch_reg <= root_pitch_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ROOT_PITCH: prdata = {28'd0, root_pitch_reg};
            REG_SCALE_MODE: prdata = {28'd0, scale_mode_reg};
            default:        prdata = '0;
        endcase
    end

    // Handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, member_reg, lower_reg, upper_reg, nearest_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_note_reg <= s_tdata[NoteW-1:0];
        if (advance && in_valid_reg)
        begin
            nearest_reg <= near_note;
            upper_reg   <= upper_next;
            lower_reg   <= lower_next;
            member_reg  <= member;
        end
    end

    // Active mask, rotated up by the root
    assign root_mod  = (root_pitch_reg >= 4'(PcCount)) ? root_pitch_reg - 4'(PcCount)
                                                        : root_pitch_reg;
    assign base_mask = scale_mask(scale_mode_reg);
    assign act_mask  = 12'(({base_mask, base_mask} << root_mod) >> PcCount);

    // Pitch class of the note: n / 12 by reciprocal, exact for n < 128
    assign n         = in_note_reg;
    assign quot_prod = 14'(n) * 14'd43;
    assign quot      = quot_prod[12:9];
    assign pc        = 4'(n - 7'(quot) * 7'd12);

    // Mask seen from the note's pitch class: bit 0 is the note itself
    assign rel_mask  = 12'({act_mask, act_mask} >> pc);
    assign member    = rel_mask[0];

    always_comb
    begin
        have_up   = 1'b0;
        have_down = 1'b0;
        up_d      = 4'd0;
        dn_d      = 4'd0;
        for (int k = PcCount; k >= 1; k--)
        begin
            if (rel_mask[4'(k % PcCount)] && ({1'b0, n} + 8'(k) <= 8'(NoteMax)))
            begin
                have_up = 1'b1;
                up_d    = 4'(k);
            end
            if (rel_mask[4'((PcCount - k) % PcCount)] && (7'(k) <= n))
            begin
                have_down = 1'b1;
                dn_d      = 4'(k);
            end
        end
    end

    assign up_note = n + 7'(up_d);
    assign dn_note = n - 7'(dn_d);

    always_comb
    begin
        if (member)
        begin
            upper_next = n;
            lower_next = n;
            near_note  = n;
        end
        else
        begin
            upper_next = have_up ? up_note : n;
            lower_next = have_down ? dn_note : n;
            if (have_up && have_down)
                near_note = (up_d < dn_d) ? up_note : dn_note;
            else if (have_up)
                near_note = up_note;
            else if (have_down)
                near_note = dn_note;
            else
                near_note = n;
        end
    end

endmodule
